FILE: hdl/ptpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpd_pkg
// Shared types and constants for the point to primitive distance pipeline.
// ----------------------------------------------------------------------------
package ptpd_pkg;

    localparam int GUARD_BITS    = 16;
    localparam int DIST_WIDTH    = 31;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int NUM_COEFS     = 7;

    localparam logic [DIST_WIDTH-1:0] DIST_MAX = '1;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_PLANE    = 2'd0;
    localparam t_kind KIND_SPHERE   = 2'd1;
    localparam t_kind KIND_CYLINDER = 2'd2;
    localparam t_kind KIND_CONE     = 2'd3;

    typedef logic [CFG_IDX_WIDTH-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_KIND   = 3'd0;
    localparam t_cfg_idx REG_COEF_0 = 3'd1;

    typedef logic [1:0] t_fifo_cnt;

    localparam t_fifo_cnt FIFO_EMPTY = 2'd0;
    localparam t_fifo_cnt FIFO_ONE   = 2'd1;
    localparam t_fifo_cnt FIFO_FULL  = 2'd2;

endpackage

FILE: hdl/point_to_primitive_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_to_primitive_distance
// Streams 3D points and returns the absolute distance to a configured plane,
// sphere, cylinder or cone, through a fully pipelined sqrt/divide datapath.
// ----------------------------------------------------------------------------
//  channel   direction  signals                          item
//  config    in         i_cfg_wr_en/index/wdata          one register write
//  points    in         s_axis_tvalid/tready/tdata       point_x, y, z
//  distance  out        m_axis_tvalid/tready/tdata       distance, degenerate
//
//  One item per cycle sustained while the output queue is not full. The
//  norm sqrt, divider and axis sqrt each resolve one bit per stage.
//  i_rst_n is synchronous, active low; it clears valids, configuration registers and queue.
//  A two-entry output queue absorbs stalls; the pipeline holds only when the
//  queue is full, and the input ready comes from a register.
// ----------------------------------------------------------------------------
module point_to_primitive_distance
    import ptpd_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    localparam int IN_DW  = ((3 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_DW = ((DIST_WIDTH + 1 + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  t_cfg_idx               i_cfg_index,
    input  logic [COORD_WIDTH-1:0] i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_DW-1:0]       s_axis_tdata,  // point_x, point_y, point_z
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DW-1:0]      m_axis_tdata   // surface_distance, degenerate
);

    localparam int W    = COORD_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int RW   = W + GUARD_BITS;
    localparam int XW   = 2 * RW;
    localparam int DRW  = W + 1;
    localparam int DDW  = 2 * DRW;
    localparam int NW   = W + ((F > W) ? F : W) + 3;
    localparam int QB   = W + 3;
    localparam int HW   = NW + GUARD_BITS - QB;
    localparam int CW   = (HW > RW) ? HW : RW;
    localparam int PW   = (QB > DIST_WIDTH) ? QB : DIST_WIDTH;
    localparam int TPW  = W + QB - F;
    localparam int FW   = W + QB + 2;
    localparam int PRW  = 2 * QB;

    // configuration
    t_kind                 r_kind;
    logic signed [W-1:0]   r_coef [NUM_COEFS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_PLANE;
            for (int k = 0; k < NUM_COEFS; k++) r_coef[k] <= '0;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == REG_KIND) r_kind <= t_kind'(i_cfg_wdata[1:0]);
            for (int k = 0; k < NUM_COEFS; k++) begin
                if (i_cfg_index == REG_COEF_0 + t_cfg_idx'(k)) r_coef[k] <= i_cfg_wdata;
            end
        end
    end

    // output queue state and global advance
    t_fifo_cnt              r_cnt;
    logic [DIST_WIDTH:0]    r_q0;
    logic [DIST_WIDTH:0]    r_q1;
    logic                   ce;
    logic                   push;
    logic                   pop;

    assign ce            = (r_cnt != FIFO_FULL);
    assign s_axis_tready = ce;

    // stage 1: input register
    logic                  r_v1;
    logic signed [W-1:0]   r_p [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (ce) r_v1 <= s_axis_tvalid;
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) r_p[k] <= s_axis_tdata[k*W +: W];
        end
    end

    // stage 2: offsets and operand select
    logic                  r_v2;
    logic signed [W:0]     r_x [3];
    logic signed [W-1:0]   r_y [3];
    logic signed [W:0]     r_d [3];
    logic signed [W:0]     n_d [3];

    always_comb begin
        for (int k = 0; k < 3; k++) n_d[k] = (W+1)'(r_p[k]) - (W+1)'(r_coef[k]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (ce) r_v2 <= r_v1;
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                r_d[k] <= n_d[k];
                if (r_kind == KIND_PLANE) begin
                    r_x[k] <= (W+1)'(r_p[k]);
                    r_y[k] <= r_coef[k];
                end else begin
                    r_x[k] <= n_d[k];
                    r_y[k] <= r_coef[3+k];
                end
            end
        end
    end

    // stage 3: products
    logic                   r_v3;
    logic signed [2*W:0]    r_xy  [3];
    logic [2*W-1:0]         r_yy  [3];
    logic [DDW-1:0]         r_dsq [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (ce) r_v3 <= r_v2;
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                r_xy[k]  <= r_x[k] * r_y[k];
                r_yy[k]  <= r_y[k] * r_y[k];
                r_dsq[k] <= r_d[k] * r_d[k];
            end
        end
    end

    // stage 4: sums, feeds the norm sqrt
    logic signed [NW-1:0]   n_num;
    logic [2*W-1:0]         n_n2;
    logic [DDW-1:0]         n_dd;
    logic signed [NW-1:0]   d_term;

    assign d_term = (r_kind == KIND_PLANE) ? (NW'(r_coef[3]) <<< F) : '0;
    assign n_num  = NW'(r_xy[0]) + NW'(r_xy[1]) + NW'(r_xy[2]) + d_term;
    assign n_n2   = r_yy[0] + r_yy[1] + r_yy[2];
    assign n_dd   = r_dsq[0] + r_dsq[1] + r_dsq[2];

    logic                   r_a_v     [0:RW];
    logic [XW-1:0]          r_a_rem   [0:RW];
    logic [RW-1:0]          r_a_root  [0:RW];
    logic [DDW-1:0]         r_a_drem  [0:RW];
    logic [DRW-1:0]         r_a_droot [0:RW];
    logic signed [NW-1:0]   r_a_num   [0:RW];
    logic [DDW-1:0]         r_a_dd    [0:RW];
    logic                   r_a_deg   [0:RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_v[0] <= 1'b0;
        else if (ce) r_a_v[0] <= r_v3;
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_a_rem[0]   <= XW'(n_n2) << (2 * GUARD_BITS);
            r_a_root[0]  <= '0;
            r_a_drem[0]  <= n_dd;
            r_a_droot[0] <= '0;
            r_a_num[0]   <= n_num;
            r_a_dd[0]    <= n_dd;
            r_a_deg[0]   <= (n_n2 == '0) && (r_kind != KIND_SPHERE);
        end
    end

    // norm sqrt and |d| sqrt, one root bit per stage
    for (genvar g = 0; g < RW; g++) begin : g_norm
        localparam int I = RW - 1 - g;
        logic [XW-1:0] trial;

        assign trial = (XW'(r_a_root[g]) << (I + 1)) | (XW'(1) << (2 * I));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_a_v[g+1] <= 1'b0;
            else if (ce) r_a_v[g+1] <= r_a_v[g];
        end

        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_a_num[g+1] <= r_a_num[g];
                r_a_dd[g+1]  <= r_a_dd[g];
                r_a_deg[g+1] <= r_a_deg[g];
                if (r_a_rem[g] >= trial) begin
                    r_a_rem[g+1]  <= r_a_rem[g] - trial;
                    r_a_root[g+1] <= r_a_root[g] | (RW'(1) << I);
                end else begin
                    r_a_rem[g+1]  <= r_a_rem[g];
                    r_a_root[g+1] <= r_a_root[g];
                end
            end
        end

        if (I < DRW) begin : g_dd
            logic [DDW-1:0] dtrial;

            assign dtrial = (DDW'(r_a_droot[g]) << (I + 1)) | (DDW'(1) << (2 * I));

            always_ff @(posedge i_clk) begin
                if (ce) begin
                    if (r_a_drem[g] >= dtrial) begin
                        r_a_drem[g+1]  <= r_a_drem[g] - dtrial;
                        r_a_droot[g+1] <= r_a_droot[g] | (DRW'(1) << I);
                    end else begin
                        r_a_drem[g+1]  <= r_a_drem[g];
                        r_a_droot[g+1] <= r_a_droot[g];
                    end
                end
            end
        end else begin : g_dd_hold
            always_ff @(posedge i_clk) begin
                if (ce) begin
                    r_a_drem[g+1]  <= r_a_drem[g];
                    r_a_droot[g+1] <= r_a_droot[g];
                end
            end
        end
    end

    // divider entry: |num| << guard, split, overflow check
    logic [NW-1:0]              n_abs;
    logic [NW+GUARD_BITS-1:0]   n_ext;
    logic [HW-1:0]              n_hi;

    assign n_abs = r_a_num[RW][NW-1] ? NW'(-r_a_num[RW]) : NW'(r_a_num[RW]);
    assign n_ext = {n_abs, {GUARD_BITS{1'b0}}};
    assign n_hi  = n_ext[NW+GUARD_BITS-1:QB];

    logic                   r_b_v     [0:QB];
    logic [RW-1:0]          r_b_rem   [0:QB];
    logic [QB-1:0]          r_b_low   [0:QB];
    logic [QB-1:0]          r_b_q     [0:QB];
    logic [RW-1:0]          r_b_den   [0:QB];
    logic                   r_b_ovf   [0:QB];
    logic                   r_b_neg   [0:QB];
    logic [DDW-1:0]         r_b_dd    [0:QB];
    logic [DRW-1:0]         r_b_droot [0:QB];
    logic                   r_b_deg   [0:QB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_v[0] <= 1'b0;
        else if (ce) r_b_v[0] <= r_a_v[RW];
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_b_rem[0]   <= RW'(n_hi);
            r_b_low[0]   <= n_ext[QB-1:0];
            r_b_q[0]     <= '0;
            r_b_den[0]   <= r_a_root[RW];
            r_b_ovf[0]   <= CW'(n_hi) >= CW'(r_a_root[RW]);
            r_b_neg[0]   <= r_a_num[RW][NW-1];
            r_b_dd[0]    <= r_a_dd[RW];
            r_b_droot[0] <= r_a_droot[RW];
            r_b_deg[0]   <= r_a_deg[RW];
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar g = 0; g < QB; g++) begin : g_div
        logic [RW:0] t;
        logic [RW:0] t_sub;

        assign t     = {r_b_rem[g], r_b_low[g][QB-1]};
        assign t_sub = t - {1'b0, r_b_den[g]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_b_v[g+1] <= 1'b0;
            else if (ce) r_b_v[g+1] <= r_b_v[g];
        end

        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_b_low[g+1]   <= r_b_low[g] << 1;
                r_b_den[g+1]   <= r_b_den[g];
                r_b_ovf[g+1]   <= r_b_ovf[g];
                r_b_neg[g+1]   <= r_b_neg[g];
                r_b_dd[g+1]    <= r_b_dd[g];
                r_b_droot[g+1] <= r_b_droot[g];
                r_b_deg[g+1]   <= r_b_deg[g];
                if (t >= {1'b0, r_b_den[g]}) begin
                    r_b_rem[g+1] <= RW'(t_sub);
                    r_b_q[g+1]   <= {r_b_q[g][QB-2:0], 1'b1};
                end else begin
                    r_b_rem[g+1] <= RW'(t);
                    r_b_q[g+1]   <= {r_b_q[g][QB-2:0], 1'b0};
                end
            end
        end
    end

    // stage M: projection products, plane result
    logic [W-1:0]           tan_mag;
    logic [W+QB-1:0]        n_tprod;
    logic [PW-1:0]          q_ext;

    assign tan_mag = r_coef[6][W-1] ? W'(-r_coef[6]) : W'(r_coef[6]);
    assign n_tprod = tan_mag * r_b_q[QB];
    assign q_ext   = PW'(r_b_q[QB]);

    logic                   r_m_v;
    logic [PRW-1:0]         r_m_pr2;
    logic [TPW-1:0]         r_m_tp;
    logic                   r_m_behind;
    logic [DIST_WIDTH-1:0]  r_m_pdist;
    logic [DDW-1:0]         r_m_dd;
    logic [DRW-1:0]         r_m_droot;
    logic                   r_m_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_m_v <= 1'b0;
        else if (ce) r_m_v <= r_b_v[QB];
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_m_pr2    <= r_b_q[QB] * r_b_q[QB];
            r_m_tp     <= n_tprod[W+QB-1:F];
            r_m_behind <= r_b_neg[QB] && (r_b_q[QB] != '0);
            r_m_pdist  <= (r_b_ovf[QB] || (q_ext > PW'(DIST_MAX))) ?
                          DIST_MAX : DIST_WIDTH'(q_ext);
            r_m_dd     <= r_b_dd[QB];
            r_m_droot  <= r_b_droot[QB];
            r_m_deg    <= r_b_deg[QB];
        end
    end

    // stage P: squared distance to axis, feeds the axis sqrt
    logic                   r_c_v      [0:DRW];
    logic [DDW-1:0]         r_c_rem    [0:DRW];
    logic [DRW-1:0]         r_c_root   [0:DRW];
    logic [TPW-1:0]         r_c_tp     [0:DRW];
    logic                   r_c_behind [0:DRW];
    logic [DIST_WIDTH-1:0]  r_c_pdist  [0:DRW];
    logic [DRW-1:0]         r_c_droot  [0:DRW];
    logic                   r_c_deg    [0:DRW];
    logic [PRW-1:0]         perp_diff;

    assign perp_diff = PRW'(r_m_dd) - r_m_pr2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c_v[0] <= 1'b0;
        else if (ce) r_c_v[0] <= r_m_v;
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_c_rem[0]    <= (PRW'(r_m_dd) >= r_m_pr2) ? DDW'(perp_diff) : '0;
            r_c_root[0]   <= '0;
            r_c_tp[0]     <= r_m_tp;
            r_c_behind[0] <= r_m_behind;
            r_c_pdist[0]  <= r_m_pdist;
            r_c_droot[0]  <= r_m_droot;
            r_c_deg[0]    <= r_m_deg;
        end
    end

    for (genvar g = 0; g < DRW; g++) begin : g_axis
        localparam int I = DRW - 1 - g;
        logic [DDW-1:0] trial;

        assign trial = (DDW'(r_c_root[g]) << (I + 1)) | (DDW'(1) << (2 * I));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_c_v[g+1] <= 1'b0;
            else if (ce) r_c_v[g+1] <= r_c_v[g];
        end

        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_c_tp[g+1]     <= r_c_tp[g];
                r_c_behind[g+1] <= r_c_behind[g];
                r_c_pdist[g+1]  <= r_c_pdist[g];
                r_c_droot[g+1]  <= r_c_droot[g];
                r_c_deg[g+1]    <= r_c_deg[g];
                if (r_c_rem[g] >= trial) begin
                    r_c_rem[g+1]  <= r_c_rem[g] - trial;
                    r_c_root[g+1] <= r_c_root[g] | (DRW'(1) << I);
                end else begin
                    r_c_rem[g+1]  <= r_c_rem[g];
                    r_c_root[g+1] <= r_c_root[g];
                end
            end
        end
    end

    // final select
    function automatic logic [DIST_WIDTH-1:0] sat_mag(input logic signed [FW-1:0] v);
        logic [FW-1:0] m;
        m = v[FW-1] ? FW'(-v) : FW'(v);
        return (m > FW'(DIST_MAX)) ? DIST_MAX : DIST_WIDTH'(m);
    endfunction

    logic signed [FW-1:0]   droot_s;
    logic signed [FW-1:0]   dax_s;
    logic signed [FW-1:0]   rad_s;
    logic signed [FW-1:0]   tan_s;
    logic signed [FW-1:0]   tp_s;
    logic signed [FW-1:0]   cone_term;
    logic [DIST_WIDTH-1:0]  n_dist;
    logic                   n_deg;

    assign droot_s   = FW'(r_c_droot[DRW]);
    assign dax_s     = FW'(r_c_root[DRW]);
    assign rad_s     = FW'(r_coef[3]);
    assign tan_s     = FW'(r_coef[6]);
    assign tp_s      = FW'(r_c_tp[DRW]);
    assign cone_term = r_coef[6][W-1] ? -tp_s : tp_s;
    assign n_deg     = r_c_deg[DRW];

    always_comb begin
        n_dist = DIST_MAX;
        unique case (r_kind)
            KIND_PLANE:    n_dist = r_c_pdist[DRW];
            KIND_SPHERE:   n_dist = sat_mag(droot_s - rad_s);
            KIND_CYLINDER: n_dist = sat_mag(dax_s - tan_s);
            KIND_CONE:     n_dist = r_c_behind[DRW] ? sat_mag(droot_s)
                                                    : sat_mag(dax_s - cone_term);
            default:       n_dist = DIST_MAX;
        endcase
        if (n_deg) n_dist = DIST_MAX;
    end

    // output queue, two entries
    assign push = ce && r_c_v[DRW];
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= FIFO_EMPTY;
        end else if (push && !pop) begin
            r_cnt <= r_cnt + t_fifo_cnt'(1);
        end else if (pop && !push) begin
            r_cnt <= r_cnt - t_fifo_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && pop) begin
            if (r_cnt == FIFO_ONE) begin
                r_q0 <= {n_deg, n_dist};
            end else begin
                r_q0 <= r_q1;
                r_q1 <= {n_deg, n_dist};
            end
        end else if (push) begin
            if (r_cnt == FIFO_EMPTY) r_q0 <= {n_deg, n_dist};
            else r_q1 <= {n_deg, n_dist};
        end else if (pop) begin
            r_q0 <= r_q1;
        end
    end

    assign m_axis_tvalid = (r_cnt != FIFO_EMPTY);
    assign m_axis_tdata  = OUT_DW'(r_q0);

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output queue count out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_cnt != FIFO_FULL))
        else $error("push into full output queue");

    a_deg_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_q0[DIST_WIDTH]) |-> (r_q0[DIST_WIDTH-1:0] == DIST_MAX))
        else $error("degenerate result without saturated distance");

    a_tail_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!ce && r_c_v[DRW]) |=> r_c_v[DRW])
        else $error("pipeline tail item lost during stall");
`endif

endmodule
